// ===== src/ptu_pkg.sv =====
// Shared types and constants for the particle table update block.
// Used by the controller, the datapath and the arithmetic unit.
// No dependencies.
package ptu_pkg;

    localparam int            ABSORB_FRAME = 60;
    localparam logic [20:0]   CHASE_RESET  = 21'd13107;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_ADD       = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_TICK_HALF = 2'd2,
        FUNC_NONE      = 2'd3
    } t_func;

    // motion modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ABSORB = 2'd1,
        MODE_FOLLOW = 2'd2,
        MODE_CHASE  = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_DELAY = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

    // arithmetic unit operations
    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_DIV  = 2'd1,
        AOP_SQRT = 2'd2
    } t_aop;

    // operand selection for the arithmetic unit
    typedef enum logic [2:0] {
        ASEL_SQ   = 3'd0,
        ASEL_SQRT = 3'd1,
        ASEL_MVM  = 3'd2,
        ASEL_MVD  = 3'd3,
        ASEL_SCM  = 3'd4,
        ASEL_SCD  = 3'd5
    } t_asel;

    // one table entry as held in memory
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] sav;
        logic [2:0][31:0] acc;
        logic [31:0]      scale;
        logic [15:0]      frame;
        logic [15:0]      life;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic  accept;
        logic  add_wr;
        logic  tick_init;
        logic  rd;
        logic  ld;
        logic  diff;
        logic  sq_acc;
        logic  dist_ld;
        logic  mv_apply;
        logic  vel;
        logic  pos;
        logic  scale;
        logic  emit;
        logic  next;
        logic  flush;
        logic  ar_start;
        t_asel ar_sel;
        logic [1:0] axis;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic alive;
        logic euler;
        logic chase_go;
        logic big;
        logic last_rd;
        logic pend_valid;
        logic out_free;
        logic ar_done;
    } t_stat;

endpackage

// ===== src/ptu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/ptu_arith.sv =====
// Shared multi-cycle arithmetic unit: 34x34 multiply in three steps,
// restoring divide and integer square root at one bit per cycle.
// Depends on ptu_pkg.
module ptu_arith (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ptu_pkg::t_aop i_op,
    input  logic [65:0]   i_a,
    input  logic [33:0]   i_b,
    output logic          o_done,
    output logic [67:0]   o_res
);
    import ptu_pkg::*;

    typedef enum logic [6:0] {
        A_IDLE = 7'h01,
        A_MUL0 = 7'h02,
        A_MUL1 = 7'h04,
        A_MUL2 = 7'h08,
        A_DIV  = 7'h10,
        A_SQRT = 7'h20,
        A_DONE = 7'h40
    } t_astate;

    t_astate     r_state, n_state;
    logic [5:0]  r_cnt;
    logic [67:0] r_w;
    logic [33:0] r_b;
    logic [34:0] r_rem;
    logic [33:0] r_root;
    logic [50:0] r_p;
    logic [67:0] r_res;

    logic [34:0] div_t;
    logic        div_ge;
    logic [36:0] sq_t;
    logic [36:0] sq_trial;
    logic        sq_ge;

    // one divide step: shift in the next numerator bit
    assign div_t  = {r_rem[33:0], r_w[53]};
    assign div_ge = div_t >= {1'b0, r_b};

    // one square root step: bring down two radicand bits
    assign sq_t     = {r_rem, r_w[67:66]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        AOP_MUL:  n_state = A_MUL0;
                        AOP_DIV:  n_state = A_DIV;
                        default:  n_state = A_SQRT;
                    endcase
                end
            end
            A_MUL0: n_state = A_MUL1;
            A_MUL1: n_state = A_MUL2;
            A_MUL2: n_state = A_DONE;
            A_DIV:  if (r_cnt == 6'd0) n_state = A_DONE;
            A_SQRT: if (r_cnt == 6'd0) n_state = A_DONE;
            A_DONE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    r_b    <= i_b;
                    r_rem  <= '0;
                    r_root <= '0;
                    if (i_op == AOP_SQRT) begin
                        r_w   <= {2'b00, i_a};
                        r_cnt <= 6'd33;
                    end else begin
                        r_w   <= {2'b00, i_a};
                        r_cnt <= 6'd53;
                    end
                end
            end
            A_MUL0: begin
                r_p <= 51'(r_w[33:0] * r_b[16:0]);
            end
            A_MUL1: begin
                r_res <= 68'(r_p);
                r_p   <= 51'(r_w[33:0] * r_b[33:17]);
            end
            A_MUL2: begin
                r_res <= r_res + {r_p, 17'b0};
            end
            A_DIV: begin
                r_rem <= div_ge ? (div_t - {1'b0, r_b}) : div_t;
                r_w   <= {r_w[67:54], r_w[52:0], div_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_res <= {14'b0, r_w[52:0], div_ge};
                end
            end
            A_SQRT: begin
                r_rem  <= sq_ge ? 35'(sq_t - sq_trial) : 35'(sq_t);
                r_root <= {r_root[32:0], sq_ge};
                r_w    <= {r_w[65:0], 2'b00};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_res <= {34'b0, r_root[32:0], sq_ge};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == A_DONE);
    assign o_res  = r_res;
endmodule

// ===== src/ptu_dp.sv =====
// Datapath: entry memory, table pointers, per-entry update registers,
// configuration registers and the output word buffer.
// Depends on ptu_pkg, ptu_ram and ptu_arith.
module ptu_dp #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptu_pkg::t_cmd       i_cmd,
    output ptu_pkg::t_stat      o_stat,
    input  logic [1:0]          i_func,
    input  logic [15:0]         i_life_frames,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_vel_x,
    input  logic signed [31:0]  i_vel_y,
    input  logic signed [31:0]  i_vel_z,
    input  logic signed [31:0]  i_acc_x,
    input  logic signed [31:0]  i_acc_y,
    input  logic signed [31:0]  i_acc_z,
    input  logic [31:0]         i_scale_pair,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_ready,
    output logic                o_valid,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic [15:0]         o_out_scale,
    output logic                o_last
);
    import ptu_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int EW = $bits(t_entry);
    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = 34'sh3_8000_0000;

    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        if (v > SAT_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // configuration
    t_mode       r_mode;
    logic [15:0] r_delay;
    logic [20:0] r_step;

    // table pointers
    logic [IW-1:0] r_head, r_rd, r_wr, head_dec, rd_inc, wr_inc;
    logic [CW-1:0] r_count, r_i, r_n;

    // item and entry registers
    t_entry           r_new;
    logic [2:0][31:0] r_tgt;
    logic             r_half;
    t_entry           r_ent;
    logic [2:0][32:0] r_mag;
    logic [2:0]       r_neg;
    logic [65:0]      r_sum;
    logic [33:0]      r_dist;
    logic [15:0]      r_sc;

    // result buffering
    logic             r_pend_valid;
    logic [2:0][31:0] r_pend_pos;
    logic [15:0]      r_pend_sc;
    logic             r_out_valid;
    logic [2:0][31:0] r_out_pos;
    logic [15:0]      r_out_sc;
    logic             r_out_last;
    logic             out_free;

    // memory and arithmetic unit hookup
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata, ram_rdata, ent_wb;
    t_aop          ar_op;
    logic [65:0]   ar_a;
    logic [33:0]   ar_b;
    logic          ar_done;
    logic [67:0]   ar_res;

    // per-entry arithmetic
    logic [15:0]             f1;
    logic                    full;
    logic [2:0][31:0]        vel_add, vel_rev, pos_new, pos_mv;
    logic signed [32:0]      half_v;
    logic signed [33:0]      step_v, mv_s;
    logic signed [32:0]      dvec [3];
    logic signed [16:0]      sdiff;
    logic [15:0]             sdmag;
    logic signed [17:0]      sc_s;
    logic [1:0]              ax;

    assign full     = (r_count == CW'(MAX_PARTICLES));
    assign f1       = r_ent.frame + 16'd1;
    assign head_dec = (r_head == '0) ? IW'(MAX_PARTICLES - 1) : r_head - 1'b1;
    assign rd_inc   = (r_rd == IW'(MAX_PARTICLES - 1)) ? '0 : r_rd + 1'b1;
    assign wr_inc   = (r_wr == IW'(MAX_PARTICLES - 1)) ? '0 : r_wr + 1'b1;
    assign out_free = !r_out_valid || i_ready;
    assign ax       = i_cmd.axis;

    // velocity, position and target difference per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vel_add[k] = sat34(34'($signed(r_ent.vel[k])) + 34'($signed(r_ent.acc[k])));
            vel_rev[k] = sat34(-34'($signed(r_ent.sav[k])) - 34'($signed(r_ent.acc[k])));
            half_v = ($signed({r_ent.vel[k][31], r_ent.vel[k]})
                      + $signed({32'b0, r_ent.vel[k][31]})) >>> 1;
            step_v = (r_half && r_mode == MODE_NORMAL) ? 34'(half_v)
                                                        : 34'($signed(r_ent.vel[k]));
            pos_new[k] = sat34(34'($signed(r_ent.pos[k])) + step_v);
            dvec[k] = 33'($signed(r_tgt[k])) - 33'($signed(r_ent.pos[k]));
            mv_s = r_neg[k] ? -34'({13'b0, ar_res[20:0]}) : 34'({13'b0, ar_res[20:0]});
            pos_mv[k] = sat34(34'($signed(r_ent.pos[k])) + mv_s);
        end
    end

    // scale interpolation pieces
    assign sdiff = $signed({1'b0, r_ent.scale[15:0]}) - $signed({1'b0, r_ent.scale[31:16]});
    assign sdmag = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
    assign sc_s  = sdiff[16] ? $signed({2'b0, r_ent.scale[31:16]}) - $signed({2'b0, ar_res[15:0]})
                             : $signed({2'b0, r_ent.scale[31:16]}) + $signed({2'b0, ar_res[15:0]});

    // operand selection for the shared unit
    always_comb begin
        ar_op = AOP_MUL;
        ar_a  = '0;
        ar_b  = '0;
        case (i_cmd.ar_sel)
            ASEL_SQ: begin
                ar_a = 66'(r_mag[ax]);
                ar_b = 34'(r_mag[ax]);
            end
            ASEL_SQRT: begin
                ar_op = AOP_SQRT;
                ar_a  = r_sum;
            end
            ASEL_MVM: begin
                ar_a = 66'(r_mag[ax]);
                ar_b = 34'(r_step);
            end
            ASEL_MVD: begin
                ar_op = AOP_DIV;
                ar_a  = 66'(ar_res[53:0]);
                ar_b  = r_dist;
            end
            ASEL_SCM: begin
                ar_a = 66'(sdmag);
                ar_b = 34'(f1);
            end
            ASEL_SCD: begin
                ar_op = AOP_DIV;
                ar_a  = 66'(ar_res[53:0]);
                ar_b  = 34'(r_ent.life);
            end
            default: begin
            end
        endcase
    end

    ptu_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ar_start),
        .i_op    (ar_op),
        .i_a     (ar_a),
        .i_b     (ar_b),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    // memory write: new entry on add, updated entry on emit
    always_comb begin
        ent_wb       = r_ent;
        ent_wb.frame = f1;
        ram_we       = (i_cmd.add_wr && !full) || i_cmd.emit;
        ram_waddr    = i_cmd.add_wr ? head_dec : r_wr;
        ram_wdata    = i_cmd.add_wr ? r_new : ent_wb;
    end

    ptu_ram #(.WIDTH(EW), .DEPTH(MAX_PARTICLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_delay <= '0;
            r_step  <= CHASE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                CFG_DELAY: r_delay <= i_cfg_data[15:0];
                CFG_STEP:  r_step  <= i_cfg_data[20:0];
                default: begin
                end
            endcase
        end
    end

    // table pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_i     <= '0;
            r_n     <= '0;
        end else begin
            if (i_cmd.add_wr && !full) begin
                r_head  <= head_dec;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.tick_init) begin
                r_rd <= r_head;
                r_wr <= r_head;
                r_i  <= '0;
                r_n  <= '0;
            end
            if (i_cmd.emit) begin
                r_wr <= wr_inc;
                r_n  <= r_n + 1'b1;
            end
            if (i_cmd.next) begin
                r_rd <= rd_inc;
                r_i  <= r_i + 1'b1;
            end
            if (i_cmd.flush) begin
                r_count <= r_n;
            end
        end
    end

    // item capture and entry update
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new.pos   <= {i_pos_z, i_pos_y, i_pos_x};
            r_new.vel   <= {i_vel_z, i_vel_y, i_vel_x};
            r_new.acc   <= {i_acc_z, i_acc_y, i_acc_x};
            r_new.sav   <= '0;
            r_new.scale <= i_scale_pair;
            r_new.frame <= '0;
            r_new.life  <= (i_life_frames == 16'd0) ? 16'd1 : i_life_frames;
            r_tgt       <= {i_pos_z, i_pos_y, i_pos_x};
            r_half      <= (i_func == FUNC_TICK_HALF);
        end
        if (i_cmd.ld) begin
            r_ent <= ram_rdata;
        end
        if (i_cmd.vel) begin
            if (r_mode == MODE_ABSORB && f1 >= 16'(ABSORB_FRAME)) begin
                r_ent.vel <= {r_ent.sav[2], vel_rev[1], vel_rev[0]};
            end else begin
                if (r_mode == MODE_ABSORB) begin
                    r_ent.sav <= r_ent.vel;
                end
                r_ent.vel <= vel_add;
            end
        end
        if (i_cmd.pos) begin
            r_ent.pos <= pos_new;
        end
        if (i_cmd.diff) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= dvec[k][32];
                r_mag[k] <= dvec[k][32] ? 33'(-dvec[k]) : 33'(dvec[k]);
            end
            r_sum <= '0;
        end
        if (i_cmd.sq_acc) begin
            r_sum <= r_sum + ar_res[65:0];
        end
        if (i_cmd.dist_ld) begin
            r_dist <= ar_res[33:0];
        end
        if (i_cmd.mv_apply) begin
            r_ent.pos[ax] <= pos_mv[ax];
        end
        if (i_cmd.scale) begin
            if (sc_s < 0) begin
                r_sc <= '0;
            end else if (sc_s > 18'sd65535) begin
                r_sc <= 16'hFFFF;
            end else begin
                r_sc <= sc_s[15:0];
            end
        end
    end

    // one result held back so the final word of a tick can be flagged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((i_cmd.emit || i_cmd.flush) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.emit || i_cmd.flush) && r_pend_valid) begin
            r_out_pos  <= r_pend_pos;
            r_out_sc   <= r_pend_sc;
            r_out_last <= i_cmd.flush;
        end
        if (i_cmd.emit) begin
            r_pend_pos <= r_ent.pos;
            r_pend_sc  <= r_sc;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_x     = $signed(r_out_pos[0]);
    assign o_out_y     = $signed(r_out_pos[1]);
    assign o_out_z     = $signed(r_out_pos[2]);
    assign o_out_scale = r_out_sc;
    assign o_last      = r_out_last;

    // status to the controller
    always_comb begin
        o_stat.full       = full;
        o_stat.empty      = (r_count == '0);
        o_stat.alive      = r_ent.frame < r_ent.life;
        o_stat.euler      = (r_mode == MODE_NORMAL) || (r_mode == MODE_ABSORB);
        o_stat.chase_go   = (r_mode == MODE_CHASE) || (r_ent.frame > r_delay);
        o_stat.big        = r_sum > 66'h1_0000_0000;
        o_stat.last_rd    = (r_i + 1'b1) == r_count;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
        o_stat.ar_done    = ar_done;
    end
endmodule

// ===== src/ptu_ctrl.sv =====
// Controller: sequences adds, the tick walk over the table and the
// per-entry update steps on the shared arithmetic unit.
// Depends on ptu_pkg.
module ptu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_func,
    output logic           o_ready,
    input  ptu_pkg::t_stat i_stat,
    output ptu_pkg::t_cmd  o_cmd
);
    import ptu_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_ADD   = 18'h00002,
        S_RD    = 18'h00004,
        S_LD    = 18'h00008,
        S_CHK   = 18'h00010,
        S_VEL   = 18'h00020,
        S_POS   = 18'h00040,
        S_DIFF  = 18'h00080,
        S_SQ    = 18'h00100,
        S_CMP   = 18'h00200,
        S_SQRT  = 18'h00400,
        S_MVM   = 18'h00800,
        S_MVD   = 18'h01000,
        S_SCM   = 18'h02000,
        S_SCD   = 18'h04000,
        S_EMIT  = 18'h08000,
        S_NEXT  = 18'h10000,
        S_FLUSH = 18'h20000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_issued, n_issued;
    logic       arith;

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        o_cmd    = '0;
        o_ready  = 1'b0;
        arith    = 1'b0;
        o_cmd.axis   = r_axis;
        o_cmd.ar_sel = ASEL_SQ;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_func)
                        FUNC_ADD: n_state = S_ADD;
                        FUNC_TICK, FUNC_TICK_HALF: begin
                            o_cmd.tick_init = 1'b1;
                            if (!i_stat.empty) n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.ld = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.alive)        n_state = S_NEXT;
                else if (i_stat.euler)    n_state = S_VEL;
                else if (i_stat.chase_go) n_state = S_DIFF;
                else                      n_state = S_POS;
            end
            S_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = i_stat.euler ? S_POS : S_SCM;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = i_stat.euler ? S_SCM : S_VEL;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_axis     = 2'd0;
                n_state    = S_SQ;
            end
            S_SQ: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_SQ;
                if (i_stat.ar_done) begin
                    o_cmd.sq_acc = 1'b1;
                    if (r_axis == 2'd2) begin
                        n_axis  = 2'd0;
                        n_state = S_CMP;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end
            end
            S_CMP: begin
                n_state = i_stat.big ? S_SQRT : S_VEL;
            end
            S_SQRT: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_SQRT;
                if (i_stat.ar_done) begin
                    o_cmd.dist_ld = 1'b1;
                    n_state       = S_MVM;
                end
            end
            S_MVM: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_MVM;
                if (i_stat.ar_done) n_state = S_MVD;
            end
            S_MVD: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_MVD;
                if (i_stat.ar_done) begin
                    o_cmd.mv_apply = 1'b1;
                    if (r_axis == 2'd2) begin
                        n_axis  = 2'd0;
                        n_state = S_VEL;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_MVM;
                    end
                end
            end
            S_SCM: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_SCM;
                if (i_stat.ar_done) n_state = S_SCD;
            end
            S_SCD: begin
                arith        = 1'b1;
                o_cmd.ar_sel = ASEL_SCD;
                if (i_stat.ar_done) begin
                    o_cmd.scale = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_stat.last_rd ? S_FLUSH : S_RD;
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // start the shared unit once per arithmetic operation
        o_cmd.ar_start = arith && !r_issued;
        n_issued       = r_issued;
        if (o_cmd.ar_start)  n_issued = 1'b1;
        if (i_stat.ar_done)  n_issued = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= 2'd0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_issued <= n_issued;
        end
    end
endmodule

// ===== src/particle_table_update.sv =====
// Particle table with per-tick Euler update, Q16.16 positions, Q8.8 scales.
// An add word is captured in idle and written to memory in the add state.
// A tick word walks the table once, newest entry first. A chasing entry
// runs a distance test, and one farther than 1.0 from the target then takes
// a square root and a multiply and divide per axis on the shared arithmetic
// unit, whose divide and square root retire one bit per cycle. Dead entries
// pass only through the read, load, check and next states. Entry memory
// needs no clearing pass after reset.
// Depends on ptu_pkg, ptu_ctrl and ptu_dp.
module particle_table_update #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_life_frames,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_acc_x,
    input  logic signed [31:0] i_acc_y,
    input  logic signed [31:0] i_acc_z,
    input  logic [31:0]        i_scale_pair,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [15:0]        o_out_scale,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ptu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    ptu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ptu_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_life_frames (i_life_frames),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_vel_z       (i_vel_z),
        .i_acc_x       (i_acc_x),
        .i_acc_y       (i_acc_y),
        .i_acc_z       (i_acc_z),
        .i_scale_pair  (i_scale_pair),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_scale   (o_out_scale),
        .o_last        (o_last)
    );
endmodule
